@@ hw/rtl/nearest_neighbor_resize_macros.svh @@
// Assertion macros for the nearest-neighbor resize block.
// Used by nearest_neighbor_resize.sv; expects clk and rst_n in scope.
`ifndef NEAREST_NEIGHBOR_RESIZE_MACROS_SVH
`define NEAREST_NEIGHBOR_RESIZE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define NNR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define NNR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/nnr_pkg.sv @@
// Shared constants, codes and word types of the nearest-neighbor resize block.
// No dependencies; used by nearest_neighbor_resize.sv.
package nnr_pkg;

  localparam int MAX_IN_SIDE  = 64;
  localparam int MAX_OUT_SIDE = 1024;
  localparam int PIXEL_BITS   = 32;

  localparam int PIX_W    = PIXEL_BITS;
  localparam int IDX_W    = $clog2(MAX_IN_SIDE);
  localparam int SIDE_W   = IDX_W + 1;
  localparam int OCOORD_W = $clog2(MAX_OUT_SIDE);
  localparam int OSIDE_W  = OCOORD_W + 1;
  localparam int DEN_W    = OSIDE_W + 1;
  localparam int PROD_W   = OSIDE_W + SIDE_W;
  localparam int REM_W    = DEN_W + IDX_W;
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_IN_SIDE * MAX_IN_SIDE;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = OSIDE_W;

  localparam logic [SIDE_W-1:0]  RST_IN_SIDE  = SIDE_W'(64);
  localparam logic [OSIDE_W-1:0] RST_OUT_SIDE = OSIDE_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_HEIGHT  = 3'd0,
    REG_IN_WIDTH   = 3'd1,
    REG_OUT_HEIGHT = 3'd2,
    REG_OUT_WIDTH  = 3'd3,
    REG_COORD_MODE = 3'd4,
    REG_ROUND_MODE = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CM_ASYM  = 2'd0,
    CM_ALIGN = 2'd1,
    CM_HALF  = 2'd2
  } coord_mode_t;

  typedef enum logic [1:0] {
    RM_FLOOR     = 2'd0,
    RM_CEIL      = 2'd1,
    RM_HALF_DOWN = 2'd2,
    RM_HALF_UP   = 2'd3
  } round_mode_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [IDX_W-1:0]    in_row;
    logic [IDX_W-1:0]    in_col;
    logic [OCOORD_W-1:0] out_row;
    logic [OCOORD_W-1:0] out_col;
    logic [PIX_W-1:0]    pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [IDX_W-1:0] src_row;
    logic [IDX_W-1:0] src_col;
  } out_word_t;

endpackage

@@ hw/rtl/nearest_neighbor_resize.sv @@
// Nearest-neighbor resize of one image plane: frame store, coordinate map, divider pipeline.
// Depends on nnr_pkg and nearest_neighbor_resize_macros.svh.
//
// Takes one word per cycle while in_stall is low, writes and reads alike, and returns
// a read's result from these stages in order: one stage builds the dividend, divisor and
// clamp limit with two small multipliers per axis, one stage forms the signed
// dividend and the clamp flags, three stages run a restoring divider at two
// quotient bits each, one stage rounds and clamps, and the last stage accesses
// the 4096 x 32 single-port frame store, whose registered read data is the
// output word. Writes travel the same stages and update the store in the last stage, so
// every read sees exactly the writes accepted before it. The store has no reset and
// needs no clearing pass; reading an entry never written returns undefined data.
// Bubbles collapse, so the input stalls only while every stage holds a word and the
// output is stalled.
`include "nearest_neighbor_resize_macros.svh"

module nearest_neighbor_resize (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [nnr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nnr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  nnr_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output nnr_pkg::out_word_t                  out_data
);

  localparam int IDX_W    = nnr_pkg::IDX_W;
  localparam int SIDE_W   = nnr_pkg::SIDE_W;
  localparam int OCOORD_W = nnr_pkg::OCOORD_W;
  localparam int OSIDE_W  = nnr_pkg::OSIDE_W;
  localparam int DEN_W    = nnr_pkg::DEN_W;
  localparam int PROD_W   = nnr_pkg::PROD_W;
  localparam int REM_W    = nnr_pkg::REM_W;
  localparam int PIX_W    = nnr_pkg::PIX_W;
  localparam int ADDR_W   = nnr_pkg::ADDR_W;

  localparam int BPS        = 2;
  localparam int DIV_STAGES = IDX_W / BPS;
  localparam int SRC_STG    = DIV_STAGES + 2;
  localparam int OUT_STG    = DIV_STAGES + 3;
  localparam int NSTG       = DIV_STAGES + 4;

  typedef struct packed {
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  lim;
    logic [DEN_W-1:0]   den;
    logic [OSIDE_W-1:0] sub;
    logic [IDX_W-1:0]   imax;
  } setup_t;

  typedef struct packed {
    logic             neg;
    logic             hi;
    logic [IDX_W-1:0] imax;
    logic [DEN_W-1:0] den;
    logic [REM_W-1:0] rem;
    logic [IDX_W-1:0] quo;
  } div_t;

  typedef struct packed {
    nnr_pkg::op_t     op;
    logic [IDX_W-1:0] wr_row;
    logic [IDX_W-1:0] wr_col;
    logic [PIX_W-1:0] pixel;
  } ctl_t;

  function automatic logic [SIDE_W-1:0] clamp_in(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] res;
    if (v == '0) begin
      res = SIDE_W'(1);
    end else if (v > SIDE_W'(nnr_pkg::MAX_IN_SIDE)) begin
      res = SIDE_W'(nnr_pkg::MAX_IN_SIDE);
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic [OSIDE_W-1:0] clamp_out(input logic [OSIDE_W-1:0] v);
    logic [OSIDE_W-1:0] res;
    if (v == '0) begin
      res = OSIDE_W'(1);
    end else if (v > OSIDE_W'(nnr_pkg::MAX_OUT_SIDE)) begin
      res = OSIDE_W'(nnr_pkg::MAX_OUT_SIDE);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Configuration registers
  logic [SIDE_W-1:0]  in_height_r, in_width_r;
  logic [OSIDE_W-1:0] out_height_r, out_width_r;
  logic [1:0]         coord_mode_r, round_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_height_r  <= nnr_pkg::RST_IN_SIDE;
      in_width_r   <= nnr_pkg::RST_IN_SIDE;
      out_height_r <= nnr_pkg::RST_OUT_SIDE;
      out_width_r  <= nnr_pkg::RST_OUT_SIDE;
      coord_mode_r <= nnr_pkg::CM_ASYM;
      round_mode_r <= nnr_pkg::RM_FLOOR;
    end else if (cfg_we) begin
      unique case (nnr_pkg::cfg_reg_t'(cfg_index))
        nnr_pkg::REG_IN_HEIGHT:  in_height_r  <= cfg_wdata[SIDE_W-1:0];
        nnr_pkg::REG_IN_WIDTH:   in_width_r   <= cfg_wdata[SIDE_W-1:0];
        nnr_pkg::REG_OUT_HEIGHT: out_height_r <= cfg_wdata[OSIDE_W-1:0];
        nnr_pkg::REG_OUT_WIDTH:  out_width_r  <= cfg_wdata[OSIDE_W-1:0];
        nnr_pkg::REG_COORD_MODE: coord_mode_r <= cfg_wdata[1:0];
        nnr_pkg::REG_ROUND_MODE: round_mode_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor loads
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] stage_en;

  always_comb begin
    stage_en[OUT_STG] = !v_r[OUT_STG] || !out_stall;
    for (int i = OUT_STG - 1; i >= 0; i--) begin
      stage_en[i] = !v_r[i] || stage_en[i + 1];
    end
  end

  assign in_stall = !stage_en[0];

  ctl_t ctl_r [0:SRC_STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (stage_en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < OUT_STG; i++) begin
        if (stage_en[i]) begin
          v_r[i] <= v_r[i - 1];
        end
      end
      // drop writes here: they finish in the store
      if (stage_en[OUT_STG]) begin
        v_r[OUT_STG] <= v_r[SRC_STG] && (ctl_r[SRC_STG].op == nnr_pkg::OP_READ);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      ctl_r[0] <= '{op: in_data.op, wr_row: in_data.in_row, wr_col: in_data.in_col,
                    pixel: in_data.pixel_in};
    end
    for (int i = 1; i <= SRC_STG; i++) begin
      if (stage_en[i]) begin
        ctl_r[i] <= ctl_r[i - 1];
      end
    end
  end

  // Stage 0: operands and clamp limit per axis (row = 0, col = 1)
  logic [OCOORD_W-1:0] ocrd [2];
  logic [SIDE_W-1:0]   isz  [2];
  logic [OSIDE_W-1:0]  osz  [2];
  setup_t              setup_nxt [2];
  setup_t              setup_r   [2];

  assign ocrd[0] = in_data.out_row;
  assign ocrd[1] = in_data.out_col;
  assign isz[0]  = clamp_in(in_height_r);
  assign isz[1]  = clamp_in(in_width_r);
  assign osz[0]  = clamp_out(out_height_r);
  assign osz[1]  = clamp_out(out_width_r);

  always_comb begin
    logic [OSIDE_W-1:0] fac_a;
    logic [SIDE_W-1:0]  fac_b;
    logic [DEN_W-1:0]   den;
    logic [OSIDE_W-1:0] sub;
    logic [IDX_W-1:0]   imax;
    for (int a = 0; a < 2; a++) begin
      imax = IDX_W'(isz[a] - SIDE_W'(1));
      unique case (nnr_pkg::coord_mode_t'(coord_mode_r))
        nnr_pkg::CM_ALIGN: begin
          if (osz[a] == OSIDE_W'(1)) begin
            fac_a = '0;
            den   = DEN_W'(1);
          end else begin
            fac_a = OSIDE_W'(ocrd[a]);
            den   = DEN_W'(osz[a] - OSIDE_W'(1));
          end
          fac_b = isz[a] - SIDE_W'(1);
          sub   = '0;
        end
        nnr_pkg::CM_HALF: begin
          fac_a = {ocrd[a], 1'b1};
          fac_b = isz[a];
          den   = {osz[a], 1'b0};
          sub   = osz[a];
        end
        default: begin
          fac_a = OSIDE_W'(ocrd[a]);
          fac_b = isz[a];
          den   = DEN_W'(osz[a]);
          sub   = '0;
        end
      endcase
      setup_nxt[a].prod = PROD_W'(fac_a) * PROD_W'(fac_b);
      setup_nxt[a].lim  = PROD_W'(imax) * PROD_W'(den);
      setup_nxt[a].den  = den;
      setup_nxt[a].sub  = sub;
      setup_nxt[a].imax = imax;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      setup_r <= setup_nxt;
    end
  end

  // Stage 1: signed dividend and clamp flags; divider stages follow
  div_t dv_nxt [0:DIV_STAGES][2];
  div_t dv_r   [0:DIV_STAGES][2];

  always_comb begin
    logic [PROD_W:0] diff;
    for (int a = 0; a < 2; a++) begin
      diff = {1'b0, setup_r[a].prod} - (PROD_W + 1)'(setup_r[a].sub);
      dv_nxt[0][a].neg  = diff[PROD_W];
      dv_nxt[0][a].hi   = !diff[PROD_W] && (diff[PROD_W-1:0] >= setup_r[a].lim);
      dv_nxt[0][a].imax = setup_r[a].imax;
      dv_nxt[0][a].den  = setup_r[a].den;
      dv_nxt[0][a].rem  = REM_W'(diff[PROD_W-1:0]);
      dv_nxt[0][a].quo  = '0;
    end
  end

  // Restoring divider, BPS quotient bits per stage, most significant first
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    always_comb begin
      div_t             w;
      logic [REM_W-1:0] sh;
      int               k;
      for (int a = 0; a < 2; a++) begin
        w = dv_r[g][a];
        for (int j = 0; j < BPS; j++) begin
          k  = IDX_W - 1 - BPS * g - j;
          sh = REM_W'(w.den) << k;
          if (w.rem >= sh) begin
            w.rem = w.rem - sh;
            w.quo = w.quo | (IDX_W'(1) << k);
          end
        end
        dv_nxt[g + 1][a] = w;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g <= DIV_STAGES; g++) begin
      if (stage_en[g + 1]) begin
        dv_r[g] <= dv_nxt[g];
      end
    end
  end

  // Round, then clamp to the input range
  logic [IDX_W-1:0] src_nxt [2];
  logic [IDX_W-1:0] src_r   [2];

  always_comb begin
    div_t             d;
    logic             up;
    logic [REM_W:0]   twice;
    logic [REM_W:0]   den_x;
    logic [IDX_W:0]   qq;
    for (int a = 0; a < 2; a++) begin
      d     = dv_r[DIV_STAGES][a];
      twice = {d.rem, 1'b0};
      den_x = (REM_W + 1)'(d.den);
      unique case (nnr_pkg::round_mode_t'(round_mode_r))
        nnr_pkg::RM_FLOOR:     up = 1'b0;
        nnr_pkg::RM_CEIL:      up = (d.rem != '0);
        nnr_pkg::RM_HALF_DOWN: up = (twice > den_x);
        nnr_pkg::RM_HALF_UP:   up = (twice >= den_x);
        default:               up = 1'b0;
      endcase
      qq = (IDX_W + 1)'(d.quo) + (IDX_W + 1)'(up);
      priority if (d.neg) begin
        src_nxt[a] = '0;
      end else if (d.hi || (qq > (IDX_W + 1)'(d.imax))) begin
        src_nxt[a] = d.imax;
      end else begin
        src_nxt[a] = qq[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[SRC_STG]) begin
      src_r <= src_nxt;
    end
  end

  // Frame store: one access per word, read data is the output register
  logic [PIX_W-1:0]  frame_mem [0:nnr_pkg::DEPTH-1];
  logic [PIX_W-1:0]  rd_pix_r;
  logic [IDX_W-1:0]  out_src_r [2];
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_go;

  assign mem_go   = stage_en[OUT_STG] && v_r[SRC_STG];
  assign mem_addr = (ctl_r[SRC_STG].op == nnr_pkg::OP_WRITE)
                  ? {ctl_r[SRC_STG].wr_row, ctl_r[SRC_STG].wr_col}
                  : {src_r[0], src_r[1]};

  always_ff @(posedge clk) begin
    if (mem_go) begin
      if (ctl_r[SRC_STG].op == nnr_pkg::OP_WRITE) begin
        frame_mem[mem_addr] <= ctl_r[SRC_STG].pixel;
      end else begin
        rd_pix_r <= frame_mem[mem_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[OUT_STG]) begin
      out_src_r <= src_r;
    end
  end

  assign out_valid = v_r[OUT_STG];
  assign out_data  = '{pixel_out: rd_pix_r, src_row: out_src_r[0], src_col: out_src_r[1]};

  // Checks
  logic rd_div_in, rd_div_out;

  assign rd_div_in  = v_r[1] && (ctl_r[1].op == nnr_pkg::OP_READ);
  assign rd_div_out = v_r[DIV_STAGES + 1] && (ctl_r[DIV_STAGES + 1].op == nnr_pkg::OP_READ);

  `NNR_ASSERT_NOW(a_div_entry,
    rd_div_in && !dv_r[0][0].neg && !dv_r[0][0].hi,
    dv_r[0][0].rem < (REM_W'(dv_r[0][0].den) << IDX_W), "row quotient exceeds index range")
  `NNR_ASSERT_NOW(a_div_exit,
    rd_div_out && !dv_r[DIV_STAGES][1].neg && !dv_r[DIV_STAGES][1].hi,
    dv_r[DIV_STAGES][1].rem < REM_W'(dv_r[DIV_STAGES][1].den), "col remainder not below divisor")
  `NNR_ASSERT_NEXT(a_write_silent,
    mem_go && (ctl_r[SRC_STG].op == nnr_pkg::OP_WRITE), !out_valid, "write word made a result")
  `NNR_ASSERT_NOW(a_stall_full, in_stall, &v_r, "input stalled with an empty stage")

endmodule

@@ verif/tb_nearest_neighbor_resize.sv @@
// Self-checking testbench for nearest_neighbor_resize: directed table, then random
// phases over many size and mode settings; reads checked against table or predictor.
// Depends on nnr_pkg and the nearest_neighbor_resize RTL.
module tb_nearest_neighbor_resize;
  import nnr_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int PHASE_ITEMS  = 78;
  localparam int RAND_PHASES  = 6;
  localparam int SETTLE       = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int LIMIT_CYCLES = 1000000;

  typedef struct {
    int in_h;
    int in_w;
    int out_h;
    int out_w;
    int cmode;
    int rmode;
  } setting_t;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;

  // predictor state
  logic [PIX_W-1:0]   plane [DEPTH];
  bit                 plane_written [DEPTH];
  logic [SIDE_W-1:0]  in_h_reg;
  logic [SIDE_W-1:0]  in_w_reg;
  logic [OSIDE_W-1:0] out_h_reg;
  logic [OSIDE_W-1:0] out_w_reg;
  logic [1:0]         coord_sel;
  logic [1:0]         round_sel;

  out_word_t pending_pixels [$];
  int        fail_count;
  int        sent_count;

  cfg_reg_t reg_order [6] = '{REG_IN_HEIGHT, REG_IN_WIDTH, REG_OUT_HEIGHT,
                              REG_OUT_WIDTH, REG_COORD_MODE, REG_ROUND_MODE};

  nearest_neighbor_resize dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  function automatic int effective_side(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Exact rational map of one output coordinate to a clamped, rounded source index.
  function automatic logic [IDX_W-1:0] source_index(int o, int isz, int osz,
                                                    logic [1:0] cm, logic [1:0] rm);
    longint num;
    longint den;
    longint q;
    longint r;
    if (cm == CM_ALIGN) begin
      if (osz == 1) begin
        num = 0;
        den = 1;
      end else begin
        num = longint'(o) * (isz - 1);
        den = osz - 1;
      end
    end else if (cm == CM_HALF) begin
      num = longint'(2 * o + 1) * isz - osz;
      den = 2 * osz;
    end else begin
      num = longint'(o) * isz;
      den = osz;
    end
    if (num < 0) return '0;
    if (num >= longint'(isz - 1) * den) return IDX_W'(isz - 1);
    q = num / den;
    r = num % den;
    case (rm)
      RM_CEIL:      if (r != 0) q++;
      RM_HALF_DOWN: if (2 * r > den) q++;
      RM_HALF_UP:   if (2 * r >= den) q++;
      default: ;
    endcase
    if (q > isz - 1) q = isz - 1;
    return IDX_W'(q);
  endfunction

  function automatic out_word_t predict_read(in_word_t w);
    out_word_t res;
    int ih;
    int iw;
    int oh;
    int ow;
    ih = effective_side(int'(in_h_reg), MAX_IN_SIDE);
    iw = effective_side(int'(in_w_reg), MAX_IN_SIDE);
    oh = effective_side(int'(out_h_reg), MAX_OUT_SIDE);
    ow = effective_side(int'(out_w_reg), MAX_OUT_SIDE);
    res.src_row   = source_index(int'(w.out_row), ih, oh, coord_sel, round_sel);
    res.src_col   = source_index(int'(w.out_col), iw, ow, coord_sel, round_sel);
    res.pixel_out = plane[{res.src_row, res.src_col}];
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return PIX_W'($urandom);
  endfunction

  function automatic dir_row_t wr_row(int r, int c, logic [PIX_W-1:0] pix);
    dir_row_t row;
    row.word          = '0;
    row.word.op       = OP_WRITE;
    row.word.in_row   = IDX_W'(r);
    row.word.in_col   = IDX_W'(c);
    row.word.pixel_in = pix;
    row.typed         = 1'b0;
    row.result        = '0;
    return row;
  endfunction

  function automatic dir_row_t rd_row(int orow, int ocol, logic [PIX_W-1:0] pix,
                                      int sr, int sc);
    dir_row_t row;
    row.word                = '0;
    row.word.op             = OP_READ;
    row.word.out_row        = OCOORD_W'(orow);
    row.word.out_col        = OCOORD_W'(ocol);
    row.typed               = 1'b1;
    row.result.pixel_out    = pix;
    row.result.src_row      = IDX_W'(sr);
    row.result.src_col      = IDX_W'(sc);
    return row;
  endfunction

  // Hold the word until accepted, then update the predictor. Returns on a falling edge.
  task automatic send_word(in_word_t w, bit typed, out_word_t given);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sent_count++;
    if (w.op == OP_WRITE) begin
      plane[{w.in_row, w.in_col}]         = w.pixel_in;
      plane_written[{w.in_row, w.in_col}] = 1'b1;
    end else begin
      pending_pixels.push_back(typed ? given : predict_read(w));
    end
    @(negedge clk);
  endtask

  task automatic sender_gap(bit quiet);
    int pick;
    int n;
    if (quiet) return;
    pick = $urandom_range(0, 99);
    n = (pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding read plus the pipeline's trailing writes.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic load_settings(setting_t s);
    int vals [6];
    vals = '{s.in_h, s.in_w, s.out_h, s.out_w, s.cmode, s.rmode};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_wdata <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
      case (reg_order[i])
        REG_IN_HEIGHT:  in_h_reg  = SIDE_W'(vals[i]);
        REG_IN_WIDTH:   in_w_reg  = SIDE_W'(vals[i]);
        REG_OUT_HEIGHT: out_h_reg = OSIDE_W'(vals[i]);
        REG_OUT_WIDTH:  out_w_reg = OSIDE_W'(vals[i]);
        REG_COORD_MODE: coord_sel = 2'(vals[i]);
        REG_ROUND_MODE: round_sel = 2'(vals[i]);
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    in_word_t  w;
    in_word_t  fill;
    out_word_t hit;
    int        oh;
    int        ow;
    w          = '0;
    w.in_row   = IDX_W'($urandom_range(0, 63));
    w.in_col   = IDX_W'($urandom_range(0, 63));
    w.pixel_in = rand_pixel();
    oh = effective_side(int'(out_h_reg), MAX_OUT_SIDE);
    ow = effective_side(int'(out_w_reg), MAX_OUT_SIDE);
    // mostly inside the output plane, now and then anywhere in the coordinate range
    if ($urandom_range(0, 7) == 0) begin
      w.out_row = OCOORD_W'($urandom_range(0, 1023));
      w.out_col = OCOORD_W'($urandom_range(0, 1023));
    end else begin
      w.out_row = OCOORD_W'($urandom_range(0, oh - 1));
      w.out_col = OCOORD_W'($urandom_range(0, ow - 1));
    end
    if ($urandom_range(0, 99) < 35) begin
      w.op = OP_WRITE;
      send_word(w, 1'b0, '0);
    end else begin
      w.op = OP_READ;
      hit  = predict_read(w);
      // fill the source pixel first so no read lands on an empty entry
      if (!plane_written[{hit.src_row, hit.src_col}]) begin
        fill          = w;
        fill.op       = OP_WRITE;
        fill.in_row   = hit.src_row;
        fill.in_col   = hit.src_col;
        fill.pixel_in = rand_pixel();
        send_word(fill, 1'b0, '0);
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  // Send about PHASE_ITEMS words, fill writes included.
  task automatic run_phase(setting_t s, bit quiet, bit mid_drain);
    int stop;
    int half;
    bit mid_done;
    drain();
    load_settings(s);
    stop     = sent_count + PHASE_ITEMS;
    half     = sent_count + PHASE_ITEMS / 2;
    mid_done = 1'b0;
    while (sent_count < stop) begin
      if (mid_drain && !mid_done && sent_count >= half) begin
        drain();
        mid_done = 1'b1;
      end
      sender_gap(quiet);
      random_item();
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected result: pixel %h src (%0d,%0d)",
                   out_data.pixel_out, out_data.src_row, out_data.src_col);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_out !== want.pixel_out || out_data.src_row !== want.src_row ||
            out_data.src_col !== want.src_col) begin
          if (fail_count < MAX_REPORTS)
            $display("mismatch: expected pixel %h src (%0d,%0d), got pixel %h src (%0d,%0d)",
                     want.pixel_out, want.src_row, want.src_col,
                     out_data.pixel_out, out_data.src_row, out_data.src_col);
          fail_count++;
        end
      end
    end
  end

  // receiver back-pressure: short and long stalls, with long quiet stretches
  initial begin : stall_driver
    int quiet;
    int busy;
    out_stall = 1'b0;
    forever begin
      quiet = ($urandom_range(0, 99) < 10) ? $urandom_range(60, 200) : $urandom_range(1, 6);
      busy  = ($urandom_range(0, 99) < 8) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      @(negedge clk) out_stall <= 1'b0;
      repeat (quiet - 1) @(negedge clk);
      @(negedge clk) out_stall <= 1'b1;
      repeat (busy - 1) @(negedge clk);
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    dir_row_t dir_rows [14];
    setting_t fixed_settings [8];
    setting_t s;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_IN_HEIGHT;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    fail_count = 0;
    sent_count = 0;
    in_h_reg   = RST_IN_SIDE;
    in_w_reg   = RST_IN_SIDE;
    out_h_reg  = RST_OUT_SIDE;
    out_w_reg  = RST_OUT_SIDE;
    coord_sel  = CM_ASYM;
    round_sel  = RM_FLOOR;
    foreach (plane_written[k]) plane_written[k] = 1'b0;

    // reset settings map 64x64 onto itself, so reads inside the plane are identity
    dir_rows = '{
      wr_row(0, 0, 32'h0000_0000),
      wr_row(63, 63, 32'hFFFF_FFFF),
      wr_row(0, 63, 32'hA5A5_A5A5),
      wr_row(63, 0, 32'h5A5A_5A5A),
      wr_row(5, 9, 32'h1234_5678),
      rd_row(0, 0, 32'h0000_0000, 0, 0),
      rd_row(63, 63, 32'hFFFF_FFFF, 63, 63),
      rd_row(1023, 1023, 32'hFFFF_FFFF, 63, 63),
      rd_row(0, 1023, 32'hA5A5_A5A5, 0, 63),
      rd_row(1023, 0, 32'h5A5A_5A5A, 63, 0),
      rd_row(5, 9, 32'h1234_5678, 5, 9),
      wr_row(5, 9, 32'hDEAD_BEEF),
      rd_row(5, 9, 32'hDEAD_BEEF, 5, 9),
      rd_row(64, 63, 32'hFFFF_FFFF, 63, 63)
    };

    fixed_settings = '{
      '{64, 64, 64, 64, CM_ASYM, RM_FLOOR},
      '{1, 1, 1, 1, CM_ALIGN, RM_FLOOR},
      '{64, 64, 1024, 1024, CM_HALF, RM_HALF_UP},
      '{0, 0, 0, 0, CM_HALF, RM_CEIL},
      '{127, 100, 2047, 1500, CM_ASYM, RM_HALF_DOWN},
      '{64, 3, 2, 7, 3, RM_CEIL},
      '{37, 64, 1024, 1, CM_ALIGN, RM_HALF_UP},
      '{64, 64, 1, 1024, CM_HALF, RM_FLOOR}
    };

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      sender_gap(i % 2 == 0);
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].result);
    end

    foreach (fixed_settings[i])
      run_phase(fixed_settings[i], i % 3 == 0, i % 2 == 1);

    for (int i = 0; i < RAND_PHASES; i++) begin
      s.in_h  = $urandom_range(1, 64);
      s.in_w  = $urandom_range(1, 64);
      s.out_h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 128);
      s.out_w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 128);
      s.cmode = $urandom_range(0, 3);
      s.rmode = $urandom_range(0, 3);
      run_phase(s, i % 3 == 2, i % 2 == 0);
    end

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
